// ===== src/pl0ts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token codes and keyword table for the PL/0 token scanner.
// No dependencies.
package pl0ts_pkg;

  localparam int unsigned KEYWORD_MAX_LEN = 9;
  localparam int unsigned NUMBER_WIDTH    = 32;
  localparam int unsigned RES_FIFO_DEPTH  = 4;

  localparam int unsigned NUM_KEYWORDS = 13;
  localparam int unsigned KW_TEXT_LEN  = 9;

  // token codes
  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_LPAREN  = 5'd1;
  localparam logic [4:0] TK_RPAREN  = 5'd2;
  localparam logic [4:0] TK_SEMI    = 5'd3;
  localparam logic [4:0] TK_COMMA   = 5'd4;
  localparam logic [4:0] TK_MINUS   = 5'd5;
  localparam logic [4:0] TK_PLUS    = 5'd6;
  localparam logic [4:0] TK_SLASH   = 5'd7;
  localparam logic [4:0] TK_STAR    = 5'd8;
  localparam logic [4:0] TK_EQ      = 5'd9;
  localparam logic [4:0] TK_CEQ     = 5'd10;
  localparam logic [4:0] TK_NE      = 5'd11;
  localparam logic [4:0] TK_LE      = 5'd12;
  localparam logic [4:0] TK_LT      = 5'd13;
  localparam logic [4:0] TK_GE      = 5'd14;
  localparam logic [4:0] TK_GT      = 5'd15;
  localparam logic [4:0] TK_IDENT   = 5'd16;
  localparam logic [4:0] TK_NUMBER  = 5'd17;
  localparam logic [4:0] TK_KW_BASE = 5'd18;

  localparam logic ERR_BAD_CHAR   = 1'b0;
  localparam logic ERR_INCOMPLETE = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COLON,
    MODE_LT,
    MODE_GT
  } scan_mode_e;

  // keyword text, right-justified in 9 bytes
  localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "begin", "call", "const", "do", "end", "if", "odd",
    "procedure", "read", "then", "var", "while", "write"
  };
  localparam int unsigned KW_LEN [NUM_KEYWORDS] = '{5, 4, 5, 2, 3, 2, 3, 9, 4, 4, 3, 5, 5};

  typedef struct packed {
    logic [4:0]  token_kind;
    logic        is_error;
    logic        error_kind;
    logic [7:0]  bad_byte;
    logic [31:0] number_value;
    logic [7:0]  ident_length;
    logic        last;
  } res_t;

  // up to two results from one item
  typedef struct packed {
    logic push0;
    logic push1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic [7:0] kw_byte(input int unsigned k, input int unsigned i);
    logic [8*KW_TEXT_LEN-1:0] t;
    t = KW_TEXT[k];
    if (i < KW_LEN[k]) begin
      return t[(KW_LEN[k] - 1 - i) * 8 +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// ===== src/pl0ts_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the token scanner: one source byte per transaction.
// No dependencies.
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== src/pl0ts_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the token scanner: one token or error per transaction.
// No dependencies.
interface pl0ts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic        is_error;
  logic        error_kind;
  logic [7:0]  bad_byte;
  logic [31:0] number_value;
  logic [7:0]  ident_length;
  logic        last;

  modport source (output valid, output token_kind, output is_error, output error_kind,
                  output bad_byte, output number_value, output ident_length,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input is_error, input error_kind,
                  input bad_byte, input number_value, input ident_length,
                  input last, output ready);
endinterface

// ===== src/pl0ts_scan_core.sv =====
`timescale 1ns / 1ps
// Scanner state and single-pass token logic: one byte in, up to two results out.
// Depends on pl0ts_pkg.
module pl0ts_scan_core #(
  parameter int unsigned KeywordMaxLen = pl0ts_pkg::KEYWORD_MAX_LEN,
  parameter int unsigned NumberWidth   = pl0ts_pkg::NUMBER_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        in_byte_i,
  input  logic              eoi_i,
  output pl0ts_pkg::push_t  push_o
);

  localparam int unsigned IdxW = $clog2(KeywordMaxLen);

  pl0ts_pkg::scan_mode_e mode_q, mode_d;
  logic [7:0]             chars_q [KeywordMaxLen];
  logic [7:0]             cnt_q, cnt_d;
  logic [NumberWidth-1:0] acc_q, acc_d;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "(":     k = pl0ts_pkg::TK_LPAREN;
      ")":     k = pl0ts_pkg::TK_RPAREN;
      ";":     k = pl0ts_pkg::TK_SEMI;
      ",":     k = pl0ts_pkg::TK_COMMA;
      "-":     k = pl0ts_pkg::TK_MINUS;
      "+":     k = pl0ts_pkg::TK_PLUS;
      "/":     k = pl0ts_pkg::TK_SLASH;
      "*":     k = pl0ts_pkg::TK_STAR;
      "=":     k = pl0ts_pkg::TK_EQ;
      default: k = pl0ts_pkg::TK_EOF;
    endcase
    return k;
  endfunction

  function automatic pl0ts_pkg::res_t mk_tok(input logic [4:0] kind);
    pl0ts_pkg::res_t r;
    r = '0;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic pl0ts_pkg::res_t mk_err(input logic ekind, input logic [7:0] bad);
    pl0ts_pkg::res_t r;
    r = '0;
    r.is_error   = 1'b1;
    r.error_kind = ekind;
    r.bad_byte   = bad;
    return r;
  endfunction

  // keyword compare on the buffered identifier
  logic       kw_hit;
  logic [4:0] kw_idx;
  logic       kw_match;

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int unsigned k = 0; k < pl0ts_pkg::NUM_KEYWORDS; k++) begin
      kw_match = (cnt_q == 8'(pl0ts_pkg::KW_LEN[k]));
      for (int unsigned i = 0; i < pl0ts_pkg::KW_TEXT_LEN; i++) begin
        if (i < pl0ts_pkg::KW_LEN[k] && chars_q[i] != pl0ts_pkg::kw_byte(k, i)) begin
          kw_match = 1'b0;
        end
      end
      if (kw_match && !kw_hit) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
  end

  // pending token of the current mode
  pl0ts_pkg::res_t pend_res;

  always_comb begin
    pend_res = '0;
    unique case (mode_q)
      pl0ts_pkg::MODE_IDENT: begin
        if (kw_hit) begin
          pend_res = mk_tok(pl0ts_pkg::TK_KW_BASE + kw_idx);
        end else begin
          pend_res = mk_tok(pl0ts_pkg::TK_IDENT);
          pend_res.ident_length = cnt_q;
        end
      end
      pl0ts_pkg::MODE_NUMBER: begin
        pend_res = mk_tok(pl0ts_pkg::TK_NUMBER);
        pend_res.number_value = 32'(acc_q);
      end
      pl0ts_pkg::MODE_COLON: pend_res = mk_err(pl0ts_pkg::ERR_INCOMPLETE, 8'h00);
      pl0ts_pkg::MODE_LT:    pend_res = mk_tok(pl0ts_pkg::TK_LT);
      pl0ts_pkg::MODE_GT:    pend_res = mk_tok(pl0ts_pkg::TK_GT);
      default:               pend_res = '0;
    endcase
  end

  // scan of the byte from idle
  logic [4:0]            sk;
  logic                  idle_emit;
  pl0ts_pkg::res_t       idle_res;
  pl0ts_pkg::scan_mode_e idle_mode;
  logic                  idle_ident, idle_num;

  always_comb begin
    sk         = single_kind(in_byte_i);
    idle_emit  = 1'b0;
    idle_res   = '0;
    idle_mode  = pl0ts_pkg::MODE_IDLE;
    idle_ident = 1'b0;
    idle_num   = 1'b0;
    priority if (is_space(in_byte_i)) begin
      idle_emit = 1'b0;
    end else if (sk != pl0ts_pkg::TK_EOF) begin
      idle_emit = 1'b1;
      idle_res  = mk_tok(sk);
    end else if (in_byte_i == ":") begin
      idle_mode = pl0ts_pkg::MODE_COLON;
    end else if (in_byte_i == "<") begin
      idle_mode = pl0ts_pkg::MODE_LT;
    end else if (in_byte_i == ">") begin
      idle_mode = pl0ts_pkg::MODE_GT;
    end else if (is_alpha(in_byte_i)) begin
      idle_mode  = pl0ts_pkg::MODE_IDENT;
      idle_ident = 1'b1;
    end else if (is_digit(in_byte_i)) begin
      idle_mode = pl0ts_pkg::MODE_NUMBER;
      idle_num  = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_res  = mk_err(pl0ts_pkg::ERR_BAD_CHAR, in_byte_i);
    end
  end

  // main decision
  logic            pa, pb;
  pl0ts_pkg::res_t ra, rb;
  logic            app_en, app_first, add_en, add_first;

  always_comb begin
    mode_d    = mode_q;
    pa        = 1'b0;
    pb        = 1'b0;
    ra        = pend_res;
    rb        = idle_res;
    app_en    = 1'b0;
    app_first = 1'b0;
    add_en    = 1'b0;
    add_first = 1'b0;
    if (eoi_i) begin
      pa     = (mode_q != pl0ts_pkg::MODE_IDLE);
      pb     = 1'b1;
      rb     = mk_tok(pl0ts_pkg::TK_EOF);
      mode_d = pl0ts_pkg::MODE_IDLE;
    end else begin
      // default: flush pending (if any) and rescan the byte from idle
      pa        = (mode_q != pl0ts_pkg::MODE_IDLE);
      pb        = idle_emit;
      mode_d    = idle_mode;
      app_en    = idle_ident;
      app_first = idle_ident;
      add_en    = idle_num;
      add_first = idle_num;
      unique case (mode_q)
        pl0ts_pkg::MODE_IDENT: begin
          if (is_alpha(in_byte_i) || is_digit(in_byte_i)) begin
            pa        = 1'b0;
            pb        = 1'b0;
            mode_d    = pl0ts_pkg::MODE_IDENT;
            app_en    = 1'b1;
            app_first = 1'b0;
            add_en    = 1'b0;
          end
        end
        pl0ts_pkg::MODE_NUMBER: begin
          if (is_digit(in_byte_i)) begin
            pa        = 1'b0;
            pb        = 1'b0;
            mode_d    = pl0ts_pkg::MODE_NUMBER;
            add_en    = 1'b1;
            add_first = 1'b0;
          end
        end
        pl0ts_pkg::MODE_COLON: begin
          // byte after ':' is always consumed
          pb     = 1'b0;
          mode_d = pl0ts_pkg::MODE_IDLE;
          app_en = 1'b0;
          add_en = 1'b0;
          if (in_byte_i == "=") begin
            ra = mk_tok(pl0ts_pkg::TK_CEQ);
          end else begin
            ra = mk_err(pl0ts_pkg::ERR_INCOMPLETE, in_byte_i);
          end
        end
        pl0ts_pkg::MODE_LT: begin
          if (in_byte_i == ">" || in_byte_i == "=") begin
            pb     = 1'b0;
            mode_d = pl0ts_pkg::MODE_IDLE;
            app_en = 1'b0;
            add_en = 1'b0;
            ra     = mk_tok((in_byte_i == ">") ? pl0ts_pkg::TK_NE : pl0ts_pkg::TK_LE);
          end
        end
        pl0ts_pkg::MODE_GT: begin
          if (in_byte_i == "=") begin
            pb     = 1'b0;
            mode_d = pl0ts_pkg::MODE_IDLE;
            app_en = 1'b0;
            add_en = 1'b0;
            ra     = mk_tok(pl0ts_pkg::TK_GE);
          end
        end
        default: begin
          pa = 1'b0;
        end
      endcase
    end
  end

  // identifier buffer and count
  logic [7:0] cnt_base;
  logic       chr_wr;

  always_comb begin
    cnt_base = app_first ? 8'd0 : cnt_q;
    cnt_d    = cnt_q;
    chr_wr   = 1'b0;
    if (app_en) begin
      chr_wr = (cnt_base < 8'(KeywordMaxLen));
      cnt_d  = (cnt_base != 8'hff) ? cnt_base + 8'd1 : cnt_base;
    end
  end

  // number accumulate: acc*10 + d, saturating
  logic [NumberWidth-1:0] acc_base;
  logic [NumberWidth+3:0] acc_ext, acc_next;

  always_comb begin
    acc_base = add_first ? '0 : acc_q;
    acc_ext  = (NumberWidth + 4)'(acc_base);
    acc_next = (acc_ext << 3) + (acc_ext << 1) + (NumberWidth + 4)'(in_byte_i - "0");
    acc_d    = acc_q;
    if (add_en) begin
      acc_d = (|acc_next[NumberWidth+3:NumberWidth]) ? '1 : acc_next[NumberWidth-1:0];
    end
  end

  // pack results
  always_comb begin
    push_o       = '0;
    push_o.push0 = step_i && (pa || pb);
    push_o.push1 = step_i && pa && pb;
    push_o.r0    = pa ? ra : rb;
    push_o.r0.last = !(pa && pb);
    push_o.r1    = rb;
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pl0ts_pkg::MODE_IDLE;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && chr_wr) begin
      chars_q[cnt_base[IdxW-1:0]] <= in_byte_i;
    end
  end

endmodule

// ===== src/pl0ts_result_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one per transaction.
// Depends on pl0ts_pkg.
module pl0ts_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pl0ts_pkg::push_t  push_i,
  output logic              room2_o,
  output logic              valid_o,
  input  logic              ready_i,
  output pl0ts_pkg::res_t   head_o
);

  localparam int unsigned Depth = pl0ts_pkg::RES_FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pl0ts_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  logic [PtrW-1:0] wp1;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];
  assign room2_o = (cnt_q <= CntW'(Depth - 2));
  assign wp1     = wp_q + PtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PtrW'(push_i.push0) + PtrW'(push_i.push1);
      rp_q  <= rp_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.push1) begin
      mem_q[wp1] <= push_i.r1;
    end
  end

endmodule

// ===== src/pl0_token_scanner.sv =====
`timescale 1ns / 1ps
// PL/0 token scanner top level: input register, scan core, result queue.
// The byte that ends a token is held in the input register; the token then goes
// to the result queue. Throughput: one byte per cycle while the queue has room
// for two results; results leave at one per cycle while ready. The queue depth sets the slack.
// Reset: asynchronous active low; clears scan mode, counters and queue pointers.
module pl0_token_scanner #(
  parameter int unsigned KeywordMaxLen = pl0ts_pkg::KEYWORD_MAX_LEN,
  parameter int unsigned NumberWidth   = pl0ts_pkg::NUMBER_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pl0ts_in_if.sink    in_i,
  pl0ts_out_if.source out_o
);

  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic             eoi_q;
  logic             step;
  logic             room2;
  pl0ts_pkg::push_t push;
  pl0ts_pkg::res_t  head;

  // process the held byte once the queue can take two results
  assign step       = in_vld_q && room2;
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.in_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

  pl0ts_scan_core #(
    .KeywordMaxLen(KeywordMaxLen),
    .NumberWidth  (NumberWidth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .in_byte_i(byte_q),
    .eoi_i    (eoi_q),
    .push_o   (push)
  );

  pl0ts_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room2_o(room2),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .head_o (head)
  );

  assign out_o.token_kind   = head.token_kind;
  assign out_o.is_error     = head.is_error;
  assign out_o.error_kind   = head.error_kind;
  assign out_o.bad_byte     = head.bad_byte;
  assign out_o.number_value = head.number_value;
  assign out_o.ident_length = head.ident_length;
  assign out_o.last         = head.last;

endmodule

// ===== bench/tb_pl0_token_scanner.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pl0_token_scanner: streams PL/0-like source, predicts tokens.
// Depends on pl0ts_pkg, pl0ts_in_if, pl0ts_out_if and the scanner RTL.
module tb_pl0_token_scanner;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } src_item_t;

  logic clk_i;
  logic rst_ni;

  pl0ts_in_if  in_if ();
  pl0ts_out_if out_if ();

  pl0_token_scanner DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  src_item_t         src_q[$];
  pl0ts_pkg::res_t   token_q[$];
  src_item_t         drv_item;
  pl0ts_pkg::res_t   want;
  logic              in_taken;
  int        errors = 0;
  int        queued_items = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  int phase_send[4] = '{0, 73, 0, 19};
  int phase_recv[4] = '{0, 0, 73, 19};

  string kw_names[pl0ts_pkg::NUM_KEYWORDS] = '{"begin", "call", "const", "do", "end", "if",
                                               "odd", "procedure", "read", "then", "var",
                                               "while", "write"};
  string op_text[15] = '{"(", ")", ";", ",", "-", "+", "/", "*", "=",
                         ":=", "<>", "<=", "<", ">=", ">"};
  string name_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // scanner state as predicted
  pl0ts_pkg::scan_mode_e mode_q = pl0ts_pkg::MODE_IDLE;
  logic [7:0]  name_chars [pl0ts_pkg::KEYWORD_MAX_LEN];
  logic [7:0]  name_len = '0;
  logic [31:0] num_acc = '0;

  // ---------------------------------------------------------------- predictor
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] c);
    case (c)
      "(": return pl0ts_pkg::TK_LPAREN;
      ")": return pl0ts_pkg::TK_RPAREN;
      ";": return pl0ts_pkg::TK_SEMI;
      ",": return pl0ts_pkg::TK_COMMA;
      "-": return pl0ts_pkg::TK_MINUS;
      "+": return pl0ts_pkg::TK_PLUS;
      "/": return pl0ts_pkg::TK_SLASH;
      "*": return pl0ts_pkg::TK_STAR;
      "=": return pl0ts_pkg::TK_EQ;
      default: return pl0ts_pkg::TK_EOF;
    endcase
  endfunction

  task automatic put_token(input logic [4:0] kind, input logic err, input logic ekind,
                           input logic [7:0] bad, input logic [31:0] num,
                           input logic [7:0] len);
    pl0ts_pkg::res_t r;
    r.token_kind   = kind;
    r.is_error     = err;
    r.error_kind   = ekind;
    r.bad_byte     = bad;
    r.number_value = num;
    r.ident_length = len;
    r.last         = 1'b0;
    token_q.push_back(r);
  endtask

  task automatic name_add(input logic [7:0] c);
    if (name_len < pl0ts_pkg::KEYWORD_MAX_LEN) name_chars[name_len] = c;
    if (name_len != 8'hFF) name_len = name_len + 8'd1;
  endtask

  task automatic num_add(input logic [7:0] c);
    logic [63:0] t;
    t = 64'(num_acc) * 64'd10 + 64'(c - "0");
    num_acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endtask

  // identifiers longer than the buffer never match a keyword
  task automatic flush_name();
    logic hit;
    logic found;
    found = 1'b0;
    if (name_len <= pl0ts_pkg::KEYWORD_MAX_LEN) begin
      for (int k = 0; k < pl0ts_pkg::NUM_KEYWORDS; k++) begin
        if (!found && kw_names[k].len() == name_len) begin
          hit = 1'b1;
          for (int i = 0; i < name_len; i++)
            if (name_chars[i] != kw_names[k].getc(i)) hit = 1'b0;
          if (hit) begin
            put_token(pl0ts_pkg::TK_KW_BASE + 5'(k), 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
            found = 1'b1;
          end
        end
      end
    end
    if (!found) put_token(pl0ts_pkg::TK_IDENT, 1'b0, 1'b0, 8'd0, 32'd0, name_len);
  endtask

  task automatic scan_fresh(input logic [7:0] b);
    mode_q = pl0ts_pkg::MODE_IDLE;
    if (is_space(b)) begin
    end else if (punct_code(b) != pl0ts_pkg::TK_EOF) begin
      put_token(punct_code(b), 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
    end else if (b == ":") begin
      mode_q = pl0ts_pkg::MODE_COLON;
    end else if (b == "<") begin
      mode_q = pl0ts_pkg::MODE_LT;
    end else if (b == ">") begin
      mode_q = pl0ts_pkg::MODE_GT;
    end else if (is_alpha(b)) begin
      name_len = '0;
      name_add(b);
      mode_q = pl0ts_pkg::MODE_IDENT;
    end else if (is_digit(b)) begin
      num_acc = '0;
      num_add(b);
      mode_q = pl0ts_pkg::MODE_NUMBER;
    end else begin
      put_token(pl0ts_pkg::TK_EOF, 1'b1, pl0ts_pkg::ERR_BAD_CHAR, b, 32'd0, 8'd0);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eoi);
    int n0;
    n0 = token_q.size();
    if (eoi) begin
      case (mode_q)
        pl0ts_pkg::MODE_IDENT:  flush_name();
        pl0ts_pkg::MODE_NUMBER:
          put_token(pl0ts_pkg::TK_NUMBER, 1'b0, 1'b0, 8'd0, num_acc, 8'd0);
        pl0ts_pkg::MODE_COLON:
          put_token(pl0ts_pkg::TK_EOF, 1'b1, pl0ts_pkg::ERR_INCOMPLETE, 8'd0, 32'd0, 8'd0);
        pl0ts_pkg::MODE_LT:
          put_token(pl0ts_pkg::TK_LT, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
        pl0ts_pkg::MODE_GT:
          put_token(pl0ts_pkg::TK_GT, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
        default: ;
      endcase
      put_token(pl0ts_pkg::TK_EOF, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
      mode_q = pl0ts_pkg::MODE_IDLE;
    end else begin
      case (mode_q)
        pl0ts_pkg::MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            name_add(b);
          end else begin
            flush_name();
            scan_fresh(b);
          end
        end
        pl0ts_pkg::MODE_NUMBER: begin
          if (is_digit(b)) begin
            num_add(b);
          end else begin
            put_token(pl0ts_pkg::TK_NUMBER, 1'b0, 1'b0, 8'd0, num_acc, 8'd0);
            scan_fresh(b);
          end
        end
        pl0ts_pkg::MODE_COLON: begin
          // the byte after a lone colon is swallowed by the error
          if (b == "=") put_token(pl0ts_pkg::TK_CEQ, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
          else put_token(pl0ts_pkg::TK_EOF, 1'b1, pl0ts_pkg::ERR_INCOMPLETE, b, 32'd0, 8'd0);
          mode_q = pl0ts_pkg::MODE_IDLE;
        end
        pl0ts_pkg::MODE_LT: begin
          mode_q = pl0ts_pkg::MODE_IDLE;
          if (b == ">") begin
            put_token(pl0ts_pkg::TK_NE, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
          end else if (b == "=") begin
            put_token(pl0ts_pkg::TK_LE, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
          end else begin
            put_token(pl0ts_pkg::TK_LT, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
            scan_fresh(b);
          end
        end
        pl0ts_pkg::MODE_GT: begin
          mode_q = pl0ts_pkg::MODE_IDLE;
          if (b == "=") begin
            put_token(pl0ts_pkg::TK_GE, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
          end else begin
            put_token(pl0ts_pkg::TK_GT, 1'b0, 1'b0, 8'd0, 32'd0, 8'd0);
            scan_fresh(b);
          end
        end
        default: scan_fresh(b);
      endcase
    end
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b);
    src_item_t it;
    it.b   = b;
    it.eoi = 1'b0;
    src_q.push_back(it);
    queued_items++;
  endtask

  task automatic push_end();
    src_item_t it;
    it.b   = 8'($urandom_range(255));
    it.eoi = 1'b1;
    src_q.push_back(it);
    queued_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s.getc(i));
  endtask

  function automatic logic [7:0] rand_space();
    int k;
    k = $urandom_range(5);
    return (k == 0) ? 8'h20 : 8'(8 + k);
  endfunction

  task automatic push_name(input int len);
    push_byte(name_set.getc($urandom_range(52)));
    for (int i = 1; i < len; i++) push_byte(name_set.getc($urandom_range(62)));
  endtask

  task automatic push_keyword();
    string w;
    int v;
    w = kw_names[$urandom_range(pl0ts_pkg::NUM_KEYWORDS - 1)];
    v = $urandom_range(99);
    if (v < 60) begin
      push_text(w);
    end else if (v < 78) begin
      push_text(w);
      push_byte(name_set.getc($urandom_range(62)));
    end else if (v < 92) begin
      push_text(w.substr(0, $urandom_range(w.len() - 2)));
    end else begin
      // case matters: capitalized keyword is an identifier
      push_byte(w.getc(0) - 8'h20);
      if (w.len() > 1) push_text(w.substr(1, w.len() - 1));
    end
  endtask

  task automatic push_lexeme();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 18) begin
      push_keyword();
    end else if (r < 35) begin
      n = ($urandom_range(199) == 0) ? $urandom_range(270, 250) : $urandom_range(12, 1);
      push_name(n);
    end else if (r < 50) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(25, 15) : $urandom_range(12, 1);
      for (int i = 0; i < n; i++) push_byte("0" + 8'($urandom_range(9)));
    end else if (r < 75) begin
      push_text(op_text[$urandom_range(14)]);
    end else if (r < 84) begin
      case ($urandom_range(2))
        0: push_byte(":");
        1: push_byte("<");
        default: push_byte(">");
      endcase
      push_byte(8'($urandom_range(255)));
    end else if (r < 91) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) push_byte(rand_space());
    end
    if ($urandom_range(99) < 55) push_byte(rand_space());
    if ($urandom_range(99) < 3) push_end();
  endtask

  task automatic push_random(input int count);
    int stop;
    stop = queued_items + count;
    while (queued_items < stop) push_lexeme();
    push_end();
  endtask

  task automatic wait_sent();
    while (src_q.size() != 0 || in_if.valid) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 60) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  // ---------------------------------------------------------------- clock, driver, monitor
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) scan_byte(in_if.in_byte, in_if.end_of_input);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (src_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = src_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= drv_item.b;
        in_if.end_of_input <= drv_item.eoi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_if.token_kind));
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 32'(out_if.token_kind), 32'(want.token_kind));
        check_field("is_error", 32'(out_if.is_error), 32'(want.is_error));
        check_field("error_kind", 32'(out_if.error_kind), 32'(want.error_kind));
        check_field("bad_byte", 32'(out_if.bad_byte), 32'(want.bad_byte));
        check_field("number_value", out_if.number_value, want.number_value);
        check_field("ident_length", 32'(out_if.ident_length), 32'(want.ident_length));
        check_field("last", 32'(out_if.last), 32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    in_if.valid        = 1'b0;
    in_if.in_byte      = 8'd0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // overflow, lone colon, '<' before a letter, '>=', bad bytes, colon at end
    push_text("a:=4294967296<b:x>=");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(":");
    push_end();

    for (int p = 0; p < 4; p++) begin
      wait_sent();
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 0) begin
        // one identifier past the length saturation point
        push_name(258);
        push_byte(" ");
      end
      push_random(290);
    end
    wait_sent();

    while (token_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== pl0_token_scanner.f =====
src/pl0ts_pkg.sv
src/pl0ts_in_if.sv
src/pl0ts_out_if.sv
src/pl0ts_scan_core.sv
src/pl0ts_result_fifo.sv
src/pl0_token_scanner.sv
bench/tb_pl0_token_scanner.sv
